### src/dqe_pkg.sv
package dqe_pkg;

  localparam int DataWidth = 32;
  localparam int OpWidth = 3;
  localparam int CountWidth = 5;
  localparam int DefaultDepth = 16;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH_REAR  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_REAR   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_STATUS     = 3'd5
  } op_e;

  // Broadcast control for the cell row. The forward chain keeps the front
  // in cell 0, the reverse chain keeps the rear in cell 0.
  typedef struct packed {
    logic f_shr;  // forward chain moves toward the back, cell 0 takes the value
    logic f_shl;  // forward chain moves toward cell 0
    logic f_put;  // the cell whose index equals the count takes the value
    logic r_shr;
    logic r_shl;
    logic r_put;
  } cell_ctl_t;

  localparam data_t EmptyValue = '1;

endpackage

### src/dqe_if.sv
interface dqe_in_if;
  import dqe_pkg::*;

  logic  valid;
  logic  ready;
  logic [OpWidth-1:0] op;
  data_t value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface dqe_out_if;
  import dqe_pkg::*;

  logic   valid;
  logic   ready;
  data_t  front_value;
  data_t  rear_value;
  count_t count;
  logic   is_empty;
  logic   is_full;
  logic   error;

  modport source (output valid, output front_value, output rear_value, output count,
                  output is_empty, output is_full, output error, input ready);
  modport sink (input valid, input front_value, input rear_value, input count,
                input is_empty, input is_full, input error, output ready);
endinterface

### src/dqe_cell.sv
module dqe_cell import dqe_pkg::*; #(
  parameter int Idx = 0,
  parameter int CntW = 5
) (
  input  logic            clk,
  input  cell_ctl_t       ctl,
  input  data_t           value,
  input  logic [CntW-1:0] occ,
  input  data_t           f_left,
  input  data_t           f_right,
  input  data_t           r_left,
  input  data_t           r_right,
  output data_t           f_q,
  output data_t           r_q
);

  data_t f_r, f_nxt;
  data_t r_r, r_nxt;
  logic  at_occ;

  assign at_occ = (occ == CntW'(Idx));

  always_comb begin
    priority if (ctl.f_shr) begin
      f_nxt = f_left;
    end else if (ctl.f_shl) begin
      f_nxt = f_right;
    end else if (ctl.f_put && at_occ) begin
      f_nxt = value;
    end else begin
      f_nxt = f_r;
    end
  end

  always_comb begin
    priority if (ctl.r_shr) begin
      r_nxt = r_left;
    end else if (ctl.r_shl) begin
      r_nxt = r_right;
    end else if (ctl.r_put && at_occ) begin
      r_nxt = value;
    end else begin
      r_nxt = r_r;
    end
  end

  // Payload only; cells beyond the count are never read.
  always_ff @(posedge clk) begin
    f_r <= f_nxt;
    r_r <= r_nxt;
  end

  assign f_q = f_r;
  assign r_q = r_r;

endmodule

### src/double_ended_queue.sv
// The result of an operation is presented in the cycle after its transfer.
// Throughput: one operation per cycle unless a result stalls; each update is
// local to a cell; timing rests on broadcast control and the cell count compare.
// Reset (synchronous, active low) empties the queue and drops any pending result;
// cell contents are not reset and read as -1 until pushed.
module double_ended_queue import dqe_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic      clk,
  input  logic      rst_n,
  dqe_in_if.sink    in_ch,
  dqe_out_if.source out_ch
);

  localparam int CntW = $clog2(DEPTH + 1);

  // The queue is held twice in a row of cells. The forward chain keeps the
  // front entry in cell 0 and the rest in order behind it; the reverse chain
  // keeps the rear entry in cell 0 and the rest in reverse order. A push or
  // pop at one end shifts that end's chain by one cell, while the other chain
  // only writes or forgets the entry at the far position given by the count.
  // Both ends therefore sit at fixed cells and no wide read mux is needed.

  logic [CntW-1:0] occ_r, occ_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            err_r, err_nxt;
  logic            accept;
  logic            full, empty;
  cell_ctl_t       ctl;

  data_t f_q [DEPTH];
  data_t r_q [DEPTH];

  assign full  = (occ_r == CntW'(DEPTH));
  assign empty = (occ_r == '0);

  // A new operation is taken whenever the pending result is gone or leaves
  // in this same cycle, so the state only changes once its result is out.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    ctl     = '0;
    occ_nxt = occ_r;
    err_nxt = 1'b0;
    unique case (in_ch.op)
      OP_PUSH_REAR: begin
        if (full) begin
          err_nxt = 1'b1;
        end else begin
          ctl.r_shr = 1'b1;
          ctl.f_put = 1'b1;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          err_nxt = 1'b1;
        end else begin
          ctl.f_shr = 1'b1;
          ctl.r_put = 1'b1;
          occ_nxt   = occ_r + 1'b1;
        end
      end
      OP_POP_REAR: begin
        if (empty) begin
          err_nxt = 1'b1;
        end else begin
          ctl.r_shl = 1'b1;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          err_nxt = 1'b1;
        end else begin
          ctl.f_shl = 1'b1;
          occ_nxt   = occ_r - 1'b1;
        end
      end
      OP_CLEAR: begin
        occ_nxt = '0;
      end
      default: begin
        // Status read and the unused codes change nothing.
      end
    endcase
    if (!accept) begin
      ctl     = '0;
      occ_nxt = occ_r;
      err_nxt = err_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      err_r       <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  // The row of cells. The left neighbor of cell 0 is the pushed value; the
  // right neighbor of the last cell feeds don't-care data that lands beyond
  // the count and is never read.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t f_left, f_right, r_left, r_right;

    if (i == 0) begin : g_first
      assign f_left = in_ch.value;
      assign r_left = in_ch.value;
    end else begin : g_inner_l
      assign f_left = f_q[i-1];
      assign r_left = r_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign f_right = '0;
      assign r_right = '0;
    end else begin : g_inner_r
      assign f_right = f_q[i+1];
      assign r_right = r_q[i+1];
    end

    dqe_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .value   (in_ch.value),
      .occ     (occ_r),
      .f_left  (f_left),
      .f_right (f_right),
      .r_left  (r_left),
      .r_right (r_right),
      .f_q     (f_q[i]),
      .r_q     (r_q[i])
    );
  end

  // The result is read straight from the state, which holds still while the
  // result waits for its transfer.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.front_value = empty ? EmptyValue : f_q[0];
  assign out_ch.rear_value  = empty ? EmptyValue : r_q[0];
  assign out_ch.count       = CountWidth'(occ_r);
  assign out_ch.is_empty    = empty;
  assign out_ch.is_full     = full;
  assign out_ch.error       = err_r;

  // The count never runs past the number of cells.
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(DEPTH))
    else $error("occupancy exceeds depth");

  // A refused push or pop leaves the count where it was.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (err_nxt == 1'b1) |=> $stable(occ_r) && err_r)
    else $error("failed operation changed the count");

  // A push into a queue with room grows it by exactly one entry.
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !full && (in_ch.op == OP_PUSH_REAR || in_ch.op == OP_PUSH_FRONT)
    |=> occ_r == $past(occ_r) + 1'b1)
    else $error("push did not add one entry");

endmodule

### bench/tb_top.sv
// Self-checking bench for the bounded double-ended queue.
// A scoreboard class mirrors the ring and predicts one status result per
// accepted operation. Plain tasks drive the operation channel, while a free
// running process drives the result channel's ready. Both sides idle at random.
module tb_top;
  import dqe_pkg::*;

  localparam int Depth         = DefaultDepth;
  localparam int IdlePercent   = 19;
  localparam int RandomItems   = 1550;
  localparam int BurstItems    = 60;
  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;

  // Codes 6 and 7 have no enum member; the block treats them as a status read.
  localparam logic [OpWidth-1:0] OpSpareLo = 3'd6;
  localparam logic [OpWidth-1:0] OpSpareHi = 3'd7;

  // Random bursts lean one way or the other so that both full and empty are
  // reached again and again.
  typedef enum int {
    LEAN_FILL,
    LEAN_DRAIN,
    LEAN_EVEN
  } lean_e;

  // One status result, in the order the output channel carries its fields.
  typedef struct packed {
    data_t  front_value;
    data_t  rear_value;
    count_t count;
    logic   is_empty;
    logic   is_full;
    logic   error;
  } deque_view_t;

  // Mirror of the ring. Slots are only ever read while they are occupied, so
  // their contents before the first push never matter.
  class deque_scoreboard;
    data_t       slots [Depth];
    int          head_slot  = 0;
    int          tail_slot  = 0;
    int          stored     = 0;
    int          mismatches = 0;
    deque_view_t expected_q [$];

    // Applies one accepted operation to the mirror and queues the status
    // that the block must report for it.
    function void note_transfer(logic [OpWidth-1:0] op, data_t value);
      logic        err;
      deque_view_t view;
      err = 1'b0;
      case (op)
        OP_PUSH_REAR: begin
          if (stored == Depth) begin
            err = 1'b1;
          end else begin
            slots[tail_slot] = value;
            tail_slot = (tail_slot + 1) % Depth;
            stored++;
          end
        end
        OP_PUSH_FRONT: begin
          if (stored == Depth) begin
            err = 1'b1;
          end else begin
            head_slot = (head_slot + Depth - 1) % Depth;
            slots[head_slot] = value;
            stored++;
          end
        end
        OP_POP_REAR: begin
          if (stored == 0) begin
            err = 1'b1;
          end else begin
            tail_slot = (tail_slot + Depth - 1) % Depth;
            stored--;
          end
        end
        OP_POP_FRONT: begin
          if (stored == 0) begin
            err = 1'b1;
          end else begin
            head_slot = (head_slot + 1) % Depth;
            stored--;
          end
        end
        OP_CLEAR: begin
          head_slot = 0;
          tail_slot = 0;
          stored    = 0;
        end
        default: begin
        end
      endcase
      if (stored == 0) begin
        view.front_value = EmptyValue;
        view.rear_value  = EmptyValue;
      end else begin
        view.front_value = slots[head_slot];
        view.rear_value  = slots[(tail_slot + Depth - 1) % Depth];
      end
      view.count    = count_t'(stored);
      view.is_empty = (stored == 0);
      view.is_full  = (stored == Depth);
      view.error    = err;
      expected_q.push_back(view);
    endfunction

    task report(string msg);
      mismatches++;
      $display("tb_top: mismatch: %s", msg);
    endtask

    // Compares one result transfer with the oldest queued status.
    task check_result(deque_view_t got);
      deque_view_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, front=%0d count=%0d",
                         got.front_value, got.count));
        return;
      end
      want = expected_q.pop_front();
      if (got.front_value !== want.front_value) begin
        report($sformatf("front_value %0d, predicted %0d", got.front_value, want.front_value));
      end
      if (got.rear_value !== want.rear_value) begin
        report($sformatf("rear_value %0d, predicted %0d", got.rear_value, want.rear_value));
      end
      if (got.count !== want.count) begin
        report($sformatf("count %0d, predicted %0d", got.count, want.count));
      end
      if (got.is_empty !== want.is_empty) begin
        report($sformatf("is_empty %b, predicted %b", got.is_empty, want.is_empty));
      end
      if (got.is_full !== want.is_full) begin
        report($sformatf("is_full %b, predicted %b", got.is_full, want.is_full));
      end
      if (got.error !== want.error) begin
        report($sformatf("error %b, predicted %b", got.error, want.error));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst_n;
  // While set, neither side inserts idle cycles.
  bit quiet_run;
  int idle_cycles;
  deque_scoreboard sb;

  dqe_in_if  in_ch ();
  dqe_out_if out_ch ();

  double_ended_queue #(
    .DEPTH(Depth)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #6 clk = ~clk;

  // The result side stalls in about one cycle out of five, except in the
  // quiet stretch.
  always @(posedge clk) begin
    out_ch.ready <= quiet_run || ($urandom_range(99) >= IdlePercent);
  end

  // Monitor for both channels. Every signal read here was last changed by a
  // nonblocking update, so the values seen are those from before the edge.
  // The operation is noted before the result is checked, so the order holds
  // even for a result that shows up in the same cycle as its operation.
  // The watchdog ends the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_ch.valid && in_ch.ready) begin
        sb.note_transfer(in_ch.op, in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result({out_ch.front_value, out_ch.rear_value, out_ch.count,
                         out_ch.is_empty, out_ch.is_full, out_ch.error});
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: no transfer for %0d cycles", WatchdogLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one operation and returns at the edge where it is accepted.
  // Valid is only lowered by an idle cycle, so back to back operations keep
  // it high without a second assignment in the same step.
  task automatic send_item(input logic [OpWidth-1:0] op, input data_t value);
    while (!quiet_run && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
  endtask

  // Holds the operation side idle until every predicted result has arrived.
  // The first wait puts the read of the count after the monitor has noted
  // the last transfer.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // Mostly uniform values, with the corners of the signed range mixed in.
  function automatic data_t pick_value();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return EmptyValue;
      3:       return '0;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Pushes dominate a fill burst and pops a drain burst. Clears stay rare
  // so that a fill burst can still reach the full queue.
  function automatic logic [OpWidth-1:0] pick_op(lean_e lean);
    int roll;
    int push_share;
    roll = $urandom_range(99);
    case (lean)
      LEAN_FILL:  push_share = 66;
      LEAN_DRAIN: push_share = 24;
      default:    push_share = 46;
    endcase
    if (roll < 1) begin
      return OP_CLEAR;
    end else if (roll < 8) begin
      return OpWidth'($urandom_range(OP_STATUS, OpSpareHi));
    end else if (roll < 8 + push_share) begin
      return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    end else begin
      return $urandom_range(1) ? OP_POP_FRONT : OP_POP_REAR;
    end
  endfunction

  // Directed opening: errors on the empty queue, the signed extremes, both
  // single-entry pops from either side, the spare codes and clears.
  task automatic directed_items();
    send_item(OP_STATUS, 32'h1234_5678);
    send_item(OP_POP_REAR, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_REAR, 32'h7FFF_FFFF);
    send_item(OP_PUSH_FRONT, 32'h8000_0000);
    send_item(OP_STATUS, EmptyValue);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_FRONT, EmptyValue);
    send_item(OP_POP_REAR, '0);
    send_item(OP_PUSH_REAR, '0);
    send_item(OP_PUSH_REAR, 32'sd1);
    send_item(OP_POP_REAR, EmptyValue);
    send_item(OpSpareLo, 32'h5555_5555);
    send_item(OpSpareHi, 32'hAAAA_AAAA);
    send_item(OP_CLEAR, EmptyValue);
    send_item(OP_POP_REAR, '0);
    send_item(OP_PUSH_FRONT, 32'h5555_5555);
    send_item(OP_PUSH_REAR, 32'hAAAA_AAAA);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_CLEAR, '0);
    send_item(OP_POP_FRONT, EmptyValue);
  endtask

  initial begin
    int    sent;
    int    burst;
    lean_e lean;
    sb           = new;
    idle_cycles  = 0;
    quiet_run    = 1'b0;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_STATUS;
    in_ch.value  = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    directed_items();

    // Random bursts, each with its own lean. Two bursts in the middle run
    // without idling on either side, and once the sender waits for every
    // pending result before it carries on.
    sent  = 0;
    burst = 0;
    while (sent < RandomItems) begin
      lean      = lean_e'($urandom_range(LEAN_EVEN));
      quiet_run = (burst == 8) || (burst == 9);
      if (burst == 14) begin
        wait_drained();
      end
      for (int i = 0; i < BurstItems; i++) begin
        send_item(pick_op(lean), pick_value());
      end
      sent += BurstItems;
      burst++;
    end
    quiet_run = 1'b0;

    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/dqe_pkg.sv
src/dqe_if.sv
src/dqe_cell.sv
src/double_ended_queue.sv
bench/tb_top.sv
